@@ rtl/core/fba_pkg.sv @@
// fba_pkg: shared types and codes for the frame bitmap allocator
// no dependencies; imported by the allocator top level
`timescale 1ns / 1ps

package fba_pkg;

  localparam int PF_W = 12;
  localparam int FC_W = 13;
  localparam int ST_W = 3;

  // one used bit per frame number that fits in a frame field
  localparam int MAX_FRAMES = 4096;

  typedef logic [PF_W-1:0] frame_t;
  typedef logic [FC_W-1:0] fcount_t;
  typedef logic [ST_W-1:0] status_t;

  localparam fcount_t FC_RESET = 13'd4096;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam status_t ST_ALLOCATED = 3'd0;
  localparam status_t ST_HELD      = 3'd1;
  localparam status_t ST_NO_FRAME  = 3'd2;
  localparam status_t ST_FREED     = 3'd3;
  localparam status_t ST_NOTHING   = 3'd4;

endpackage

@@ rtl/core/fba_bitmap.sv @@
// fba_bitmap: used-bit word memory, one read and one write port, read data registered
// rows not written since reset read as zero through per-row valid flops
`timescale 1ns / 1ps

module fba_bitmap #(
  parameter int NUM_WORDS = 128,
  parameter int WORD_BITS = 32,
  parameter int IDX_W     = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output logic [WORD_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [WORD_BITS-1:0] wr_data
);

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] row_vld_r;
  logic [WORD_BITS-1:0] rd_word_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= row_vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_word_r : '0;

endmodule

@@ rtl/core/frame_bitmap_allocator_top.sv @@
// frame_bitmap_allocator_top: first-fit frame allocator over a used-bit bitmap
// uses fba_pkg and fba_bitmap; the user must keep WORD_BITS a power of two, the block does not check it
// held, nothing-to-free and zero-limit items are answered straight from idle; a free of a real frame
// reads the word, then writes it back; an allocation reads words in order until the scan ends, busy meanwhile
// a new item is taken only while not busy; a scan reads up to 128 words, one per cycle;
// the receiver cannot stall. reset: synchronous, limit register to 4096, every row free
`timescale 1ns / 1ps

module frame_bitmap_allocator_top #(
  parameter int WORD_BITS  = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  fba_pkg::fcount_t cfg_wdata,
  input  logic             start,
  output logic             busy,
  input  logic             in_cmd,
  input  fba_pkg::frame_t  in_page_frame,
  input  logic             in_kernel,
  input  logic             in_rw,
  output logic             out_strobe,
  output fba_pkg::frame_t  out_frame,
  output logic             out_present,
  output logic             out_writable,
  output logic             out_user,
  output fba_pkg::status_t out_status
);
  import fba_pkg::*;

  localparam int NUM_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int IDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int WB_LOG    = $clog2(WORD_BITS);
  localparam int LIM_W     = $clog2(MAX_FRAMES + 1);
  localparam int WIDE_W    = ((LIM_W > FC_W) ? LIM_W : FC_W) + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FREE = 2'd2;

  logic [1:0]           state_r, state_nxt;
  fcount_t              frames_cfg_r;
  logic [WIDE_W-1:0]    limit_r, limit_nxt;
  logic                 wr_flag_r, wr_flag_nxt;
  logic                 kern_r, kern_nxt;
  logic [IDX_W-1:0]     free_idx_r, free_idx_nxt;
  logic [WB_LOG-1:0]    free_bit_r, free_bit_nxt;
  logic [IDX_W-1:0]     scan_addr_r, scan_addr_nxt;
  logic [WIDE_W-1:0]    scan_base_r, scan_base_nxt;
  logic [IDX_W-1:0]     chk_addr_r, chk_addr_nxt;
  logic [WIDE_W-1:0]    chk_base_r, chk_base_nxt;

  logic                 out_strobe_r, out_strobe_nxt;
  frame_t               out_frame_r, out_frame_nxt;
  logic                 out_present_r, out_present_nxt;
  logic                 out_writable_r, out_writable_nxt;
  logic                 out_user_r, out_user_nxt;
  status_t              out_status_r, out_status_nxt;

  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  logic [WIDE_W-1:0]    fc_w, lim_in, pf_w, pf_word_w;
  logic [WIDE_W-1:0]    remain, found;
  logic [WORD_BITS-1:0] lim_mask, free_bits;
  logic                 any_free, last_word;
  logic [WB_LOG-1:0]    free_pos;

  fba_bitmap #(
    .NUM_WORDS(NUM_WORDS),
    .WORD_BITS(WORD_BITS),
    .IDX_W    (IDX_W)
  ) u_bitmap (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  assign fc_w      = WIDE_W'(frames_cfg_r);
  assign lim_in    = (fc_w > WIDE_W'(MAX_FRAMES)) ? WIDE_W'(MAX_FRAMES) : fc_w;
  assign pf_w      = WIDE_W'(in_page_frame);
  assign pf_word_w = pf_w >> WB_LOG;

  // word under test: mask bits at or past the limit, pick the lowest free one
  assign remain    = limit_r - chk_base_r;
  assign last_word = remain <= WIDE_W'(WORD_BITS);
  assign lim_mask  = (remain >= WIDE_W'(WORD_BITS)) ? '1 :
                     ((WORD_BITS'(1) << remain[WB_LOG-1:0]) - WORD_BITS'(1));
  assign free_bits = ~rd_data & lim_mask;
  assign any_free  = |free_bits;
  assign found     = chk_base_r + WIDE_W'(free_pos);

  always_comb begin
    free_pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        free_pos = WB_LOG'(i);
      end
    end
  end

  always_comb begin
    state_nxt        = state_r;
    limit_nxt        = limit_r;
    wr_flag_nxt      = wr_flag_r;
    kern_nxt         = kern_r;
    free_idx_nxt     = free_idx_r;
    free_bit_nxt     = free_bit_r;
    scan_addr_nxt    = scan_addr_r;
    scan_base_nxt    = scan_base_r;
    chk_addr_nxt     = chk_addr_r;
    chk_base_nxt     = chk_base_r;
    out_strobe_nxt   = 1'b0;
    out_frame_nxt    = out_frame_r;
    out_present_nxt  = out_present_r;
    out_writable_nxt = out_writable_r;
    out_user_nxt     = out_user_r;
    out_status_nxt   = out_status_r;
    rd_en            = 1'b0;
    rd_addr          = scan_addr_r;
    wr_en            = 1'b0;
    wr_addr          = chk_addr_r;
    wr_data          = rd_data | (WORD_BITS'(1) << free_pos);

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          wr_flag_nxt      = in_rw;
          kern_nxt         = in_kernel;
          limit_nxt        = lim_in;
          out_frame_nxt    = '0;
          out_present_nxt  = 1'b0;
          out_writable_nxt = 1'b0;
          out_user_nxt     = 1'b0;
          if (in_cmd == CMD_ALLOC) begin
            if (in_page_frame != '0) begin
              out_strobe_nxt = 1'b1;
              out_frame_nxt  = in_page_frame;
              out_status_nxt = ST_HELD;
            end else if (lim_in == '0) begin
              out_strobe_nxt = 1'b1;
              out_status_nxt = ST_NO_FRAME;
            end else begin
              rd_en         = 1'b1;
              rd_addr       = '0;
              chk_addr_nxt  = '0;
              chk_base_nxt  = '0;
              scan_addr_nxt = IDX_W'(1);
              scan_base_nxt = WIDE_W'(WORD_BITS);
              state_nxt     = S_SCAN;
            end
          end else begin
            if (in_page_frame == '0) begin
              out_strobe_nxt = 1'b1;
              out_status_nxt = ST_NOTHING;
            end else if (pf_w >= WIDE_W'(MAX_FRAMES)) begin
              out_strobe_nxt = 1'b1;
              out_status_nxt = ST_FREED;
            end else begin
              rd_en        = 1'b1;
              rd_addr      = pf_word_w[IDX_W-1:0];
              free_idx_nxt = pf_word_w[IDX_W-1:0];
              free_bit_nxt = in_page_frame[WB_LOG-1:0];
              state_nxt    = S_FREE;
            end
          end
        end
      end
      S_SCAN: begin
        if (any_free) begin
          wr_en            = 1'b1;
          out_strobe_nxt   = 1'b1;
          out_frame_nxt    = found[PF_W-1:0];
          out_present_nxt  = 1'b1;
          out_writable_nxt = wr_flag_r;
          out_user_nxt     = ~kern_r;
          out_status_nxt   = ST_ALLOCATED;
          state_nxt        = S_IDLE;
        end else if (last_word) begin
          out_strobe_nxt = 1'b1;
          out_status_nxt = ST_NO_FRAME;
          state_nxt      = S_IDLE;
        end else begin
          rd_en         = 1'b1;
          chk_addr_nxt  = scan_addr_r;
          chk_base_nxt  = scan_base_r;
          scan_addr_nxt = scan_addr_r + IDX_W'(1);
          scan_base_nxt = scan_base_r + WIDE_W'(WORD_BITS);
        end
      end
      S_FREE: begin
        wr_en          = 1'b1;
        wr_addr        = free_idx_r;
        wr_data        = rd_data & ~(WORD_BITS'(1) << free_bit_r);
        out_strobe_nxt = 1'b1;
        out_status_nxt = ST_FREED;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      frames_cfg_r <= FC_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        frames_cfg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    limit_r        <= limit_nxt;
    wr_flag_r      <= wr_flag_nxt;
    kern_r         <= kern_nxt;
    free_idx_r     <= free_idx_nxt;
    free_bit_r     <= free_bit_nxt;
    scan_addr_r    <= scan_addr_nxt;
    scan_base_r    <= scan_base_nxt;
    chk_addr_r     <= chk_addr_nxt;
    chk_base_r     <= chk_base_nxt;
    out_frame_r    <= out_frame_nxt;
    out_present_r  <= out_present_nxt;
    out_writable_r <= out_writable_nxt;
    out_user_r     <= out_user_nxt;
    out_status_r   <= out_status_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_strobe   = out_strobe_r;
  assign out_frame    = out_frame_r;
  assign out_present  = out_present_r;
  assign out_writable = out_writable_r;
  assign out_user     = out_user_r;
  assign out_status   = out_status_r;

  a_result_or_work: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe))
    else $error("accepted item neither busy nor answered");

  a_free_one_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FREE) |=> (out_strobe && state_r == S_IDLE))
    else $error("free write back did not finish in one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while still busy");

  a_alloc_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_ALLOCATED) |-> (WIDE_W'(out_frame) < limit_r))
    else $error("allocated frame at or past the limit");

endmodule

@@ test/tb_frame_bitmap_allocator_top.sv @@
// tb_frame_bitmap_allocator_top: self-checking bench for the first-fit frame allocator
// predicts each result from a bit-per-frame shadow bitmap and checks every out_strobe item
// depends on fba_pkg and frame_bitmap_allocator_top
`timescale 1ns / 1ps

module tb_frame_bitmap_allocator_top;
  import fba_pkg::*;

  localparam int NUM_FRAMES  = 4096;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic   cmd;
    frame_t page_frame;
    logic   kernel;
    logic   rw;
  } frame_req_t;

  typedef struct packed {
    frame_t  frame;
    logic    present;
    logic    writable;
    logic    user;
    status_t status;
  } page_entry_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    cfg_we = 1'b0;
  fcount_t cfg_wdata = '0;
  logic    start = 1'b0;
  logic    busy;
  logic    in_cmd = CMD_ALLOC;
  frame_t  in_page_frame = '0;
  logic    in_kernel = 1'b0;
  logic    in_rw = 1'b0;
  logic    out_strobe;
  frame_t  out_frame;
  logic    out_present;
  logic    out_writable;
  logic    out_user;
  status_t out_status;

  frame_req_t  pending_reqs[$];
  page_entry_t expected_entries[$];
  frame_req_t  cur_req;

  bit [NUM_FRAMES-1:0] used_frames = '0;
  fcount_t frame_limit = FC_RESET;

  int  items_queued = 0;
  int  items_accepted = 0;
  int  results_seen = 0;
  int  mismatch_count = 0;
  int  cfg_writes = 0;
  int  gap_left = 0;
  int  stall_cycles = 0;
  int  status_seen[5] = '{default: 0};
  bit  idling_on = 1'b1;

  always #10 clk = ~clk;

  frame_bitmap_allocator_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_page_frame   (in_page_frame),
    .in_kernel       (in_kernel),
    .in_rw           (in_rw),
    .out_strobe      (out_strobe),
    .out_frame       (out_frame),
    .out_present     (out_present),
    .out_writable    (out_writable),
    .out_user        (out_user),
    .out_status      (out_status)
  );

  // first-fit allocate or free against the shadow bitmap
  function automatic page_entry_t serve_request(input frame_req_t req);
    page_entry_t entry;
    int          span;
    int          hit;
    entry = '0;
    if (req.cmd == CMD_ALLOC) begin
      if (req.page_frame != '0) begin
        entry.frame  = req.page_frame;
        entry.status = ST_HELD;
      end else begin
        span = (int'(frame_limit) > NUM_FRAMES) ? NUM_FRAMES : int'(frame_limit);
        hit  = -1;
        for (int f = 0; f < span && hit < 0; f++) begin
          if (!used_frames[f]) hit = f;
        end
        if (hit >= 0) begin
          used_frames[hit] = 1'b1;
          entry.frame      = frame_t'(hit);
          entry.present    = 1'b1;
          entry.writable   = req.rw;
          entry.user       = ~req.kernel;
          entry.status     = ST_ALLOCATED;
        end else begin
          entry.status = ST_NO_FRAME;
        end
      end
    end else begin
      if (req.page_frame != '0) begin
        used_frames[req.page_frame] = 1'b0;
        entry.status = ST_FREED;
      end else begin
        entry.status = ST_NOTHING;
      end
    end
    return entry;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch %s at %0t ns: got %0d expected %0d", what, $time, got, want);
  endtask

  task automatic queue_req(input logic cmd, input int pf, input logic kern, input logic wr);
    frame_req_t req;
    req.cmd        = cmd;
    req.page_frame = frame_t'(pf);
    req.kernel     = kern;
    req.rw         = wr;
    pending_reqs.push_back(req);
    items_queued++;
  endtask

  task automatic wait_drained();
    while (results_seen != items_queued) @(posedge clk);
  endtask

  task automatic set_frame_count(input fcount_t value);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    frame_limit = value;
    cfg_writes++;
  endtask

  task automatic queue_random(input int count, input int alloc_pct);
    int   span;
    int   pick;
    int   pf;
    logic kern;
    logic wr;
    span = (int'(frame_limit) > NUM_FRAMES) ? NUM_FRAMES : int'(frame_limit);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      kern = 1'($urandom_range(0, 1));
      wr   = 1'($urandom_range(0, 1));
      if (pick < alloc_pct) begin
        queue_req(CMD_ALLOC, 0, kern, wr);
      end else if (pick < alloc_pct + 8) begin
        queue_req(CMD_ALLOC, $urandom_range(1, NUM_FRAMES - 1), kern, wr);
      end else if (pick < alloc_pct + 11) begin
        queue_req(CMD_FREE, 0, kern, wr);
      end else begin
        if (span < 2 || $urandom_range(0, 4) == 0) pf = $urandom_range(1, NUM_FRAMES - 1);
        else pf = $urandom_range(1, span - 1);
        queue_req(CMD_FREE, pf, kern, wr);
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    logic hold_start;
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left = 0;
    end else begin
      hold_start = start;
      if (start && !busy) begin
        expected_entries.push_back(serve_request(cur_req));
        items_accepted++;
        hold_start = 1'b0;
      end
      if (!hold_start && pending_reqs.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (idling_on && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(0, 2);
        end else begin
          cur_req       = pending_reqs.pop_front();
          in_cmd        <= cur_req.cmd;
          in_page_frame <= cur_req.page_frame;
          in_kernel     <= cur_req.kernel;
          in_rw         <= cur_req.rw;
          hold_start    = 1'b1;
        end
      end
      start <= hold_start;
    end
  end

  // monitor
  always @(posedge clk) begin
    page_entry_t want;
    if (rst_n && out_strobe) begin
      results_seen++;
      if (expected_entries.size() == 0) begin
        report_mismatch("unexpected result, status", int'(out_status), 0);
      end else begin
        want = expected_entries.pop_front();
        if (int'(want.status) < 5) status_seen[want.status]++;
        if (out_frame !== want.frame)
          report_mismatch("frame", int'(out_frame), int'(want.frame));
        if (out_present !== want.present)
          report_mismatch("present", int'(out_present), int'(want.present));
        if (out_writable !== want.writable)
          report_mismatch("writable", int'(out_writable), int'(want.writable));
        if (out_user !== want.user)
          report_mismatch("user", int'(out_user), int'(want.user));
        if (out_status !== want.status)
          report_mismatch("status", int'(out_status), int'(want.status));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int phase_fc[9]  = '{37, 32, 64, 33, 300, 8191, 160, 4096, 4064};
    int phase_cnt[9] = '{120, 100, 150, 100, 250, 150, 150, 150, 130};
    int phase_pct[9] = '{70, 75, 60, 65, 75, 55, 70, 60, 65};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset limit: fill from frame 0, held pages, holes, a free of frame 0 and of a never-allocated frame
    queue_req(CMD_ALLOC, 0, 1'b0, 1'b0);
    queue_req(CMD_ALLOC, 0, 1'b1, 1'b1);
    queue_req(CMD_ALLOC, 0, 1'b0, 1'b1);
    queue_req(CMD_ALLOC, 0, 1'b1, 1'b0);
    queue_req(CMD_ALLOC, NUM_FRAMES - 1, 1'b1, 1'b1);
    queue_req(CMD_ALLOC, 1, 1'b0, 1'b0);
    queue_req(CMD_FREE, 0, 1'b1, 1'b1);
    queue_req(CMD_FREE, 2, 1'b0, 1'b0);
    queue_req(CMD_ALLOC, 0, 1'b0, 1'b1);
    queue_req(CMD_FREE, NUM_FRAMES - 1, 1'b0, 1'b0);
    queue_req(CMD_FREE, 3, 1'b1, 1'b0);
    queue_req(CMD_FREE, 1, 1'b0, 1'b1);
    queue_req(CMD_ALLOC, 0, 1'b1, 1'b1);

    // zero limit: every search allocation fails, a held page is still answered, frees still work
    set_frame_count('0);
    queue_req(CMD_ALLOC, 0, 1'b0, 1'b1);
    queue_req(CMD_FREE, 2, 1'b0, 1'b0);
    queue_req(CMD_ALLOC, 0, 1'b1, 1'b0);
    queue_req(CMD_ALLOC, 2048, 1'b0, 1'b1);
    queue_req(CMD_FREE, 0, 1'b0, 1'b0);

    // all-ones register clamps to the full bitmap
    set_frame_count(fcount_t'(8191));
    queue_req(CMD_ALLOC, 0, 1'b0, 1'b1);
    queue_req(CMD_ALLOC, 0, 1'b1, 1'b1);

    for (int p = 0; p < 9; p++) begin
      set_frame_count(fcount_t'(phase_fc[p]));
      if (p == 8) idling_on = 1'b0;
      queue_random(phase_cnt[p], phase_pct[p]);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (expected_entries.size() != 0)
      report_mismatch("results never seen, count", 0, expected_entries.size());

    $display("ran %0d items over %0d frame limit writes, limits 0 to 8191",
             items_accepted, cfg_writes);
    $display("allocated %0d, already held %0d, no free frame %0d, freed %0d, nothing %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/fba_pkg.sv
rtl/core/fba_bitmap.sv
rtl/core/frame_bitmap_allocator_top.sv
test/tb_frame_bitmap_allocator_top.sv
